// ===== hw/rtl/voice_activity_gate_unit_assert.svh =====
// ----------------------------------------------------------------------------
// Voice activity gate assertion macros
// Concurrent assertion wrappers that compile away when SYNTHESIS is defined.
// ----------------------------------------------------------------------------
`ifndef VOICE_ACTIVITY_GATE_UNIT_ASSERT_SVH
`define VOICE_ACTIVITY_GATE_UNIT_ASSERT_SVH
`ifndef SYNTHESIS
// Same-cycle implication, checked at every rising edge outside reset.
`define VAG_ASSERT_IMPL(lbl, clk_i, rst_ni, ant, cons) \
	lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ant) |-> (cons)) \
		else $error("voice activity gate assertion failed");
// Next-cycle implication, checked at every rising edge outside reset.
`define VAG_ASSERT_NEXT(lbl, clk_i, rst_ni, ant, cons) \
	lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ant) |=> (cons)) \
		else $error("voice activity gate assertion failed");
`else
`define VAG_ASSERT_IMPL(lbl, clk_i, rst_ni, ant, cons)
`define VAG_ASSERT_NEXT(lbl, clk_i, rst_ni, ant, cons)
`endif
`endif

// ===== hw/rtl/vag_pkg.sv =====
// ----------------------------------------------------------------------------
// Voice activity gate package
// Shared types, register indexes, reset values and width helpers.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

package vag_pkg;

	// Default number of stereo frames in one analysis window.
	localparam int WINDOW_FRAMES_DEFAULT = 8;

	// Field widths.
	localparam int SAMPLE_W = 16;
	localparam int AVG_W    = 16;
	localparam int REG_W    = 16;
	localparam int INDEX_W  = 2;

	// Register indexes on the configuration port.
	localparam logic [INDEX_W-1:0] REG_NOISE_GATE       = 2'd0;
	localparam logic [INDEX_W-1:0] REG_START_THRESHOLD  = 2'd1;
	localparam logic [INDEX_W-1:0] REG_HANGOVER_WINDOWS = 2'd2;

	// Register reset values.
	localparam logic [REG_W-1:0] NOISE_GATE_RESET       = 16'd300;
	localparam logic [REG_W-1:0] START_THRESHOLD_RESET  = 16'd800;
	localparam logic [REG_W-1:0] HANGOVER_WINDOWS_RESET = 16'd20;

	// Detector states, encoded as reported on the result channel.
	typedef enum logic [1:0] {
		VAG_IDLE    = 2'd0,
		VAG_START   = 2'd1,
		VAG_ONGOING = 2'd2,
		VAG_SILENCE = 2'd3
	} vag_state_t;

	// Configuration register set handed to the detector.
	typedef struct packed {
		logic [REG_W-1:0] noise_gate;
		logic [REG_W-1:0] start_threshold;
		logic [REG_W-1:0] hangover_windows;
	} vag_cfg_t;

	// Bits needed for a window sum: each frame adds at most 65536.
	function automatic int sum_width(input int frames);
		return $clog2(65536 * frames + 1);
	endfunction

endpackage

`default_nettype wire

// ===== hw/rtl/vag_if.sv =====
// ----------------------------------------------------------------------------
// Voice activity gate channels
// Valid/ready interfaces for the frame input and the window result output.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

// One stereo PCM frame per transaction.
interface vag_frame_if;
	logic                                 valid;
	logic                                 ready;
	logic signed [vag_pkg::SAMPLE_W-1:0]  left_sample;
	logic signed [vag_pkg::SAMPLE_W-1:0]  right_sample;

	modport source (output valid, output left_sample, output right_sample, input ready);
	modport sink   (input valid, input left_sample, input right_sample, output ready);
endinterface

// One finished window per transaction.
interface vag_result_if;
	logic                        valid;
	logic                        ready;
	logic [vag_pkg::AVG_W-1:0]   window_average;
	logic [1:0]                  detector_state;
	logic                        keep_window;

	modport source (output valid, output window_average, output detector_state,
		output keep_window, input ready);
	modport sink   (input valid, input window_average, input detector_state,
		input keep_window, output ready);
endinterface

`default_nettype wire

// ===== hw/rtl/vag_accum.sv =====
// ----------------------------------------------------------------------------
// Voice activity gate window accumulator
// Sums sample magnitudes over a window and registers each finished sum.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module vag_accum #(
	parameter int WINDOW_FRAMES = vag_pkg::WINDOW_FRAMES_DEFAULT,
	parameter int SUM_W         = vag_pkg::sum_width(WINDOW_FRAMES)
) (
	input  wire logic             clk,
	input  wire logic             arst_n,
	vag_frame_if.sink             frame,
	output logic                  win_valid,
	input  wire logic             win_ready,
	output logic [SUM_W-1:0]      win_sum
);

	localparam int CNT_W = (WINDOW_FRAMES > 1) ? $clog2(WINDOW_FRAMES) : 1;
	localparam logic [CNT_W-1:0] LAST_FRAME = CNT_W'(WINDOW_FRAMES - 1);

	logic [CNT_W-1:0] frame_cnt_q;
	logic [SUM_W-1:0] sum_q;
	logic [SUM_W-1:0] win_sum_s1;
	logic             win_valid_s1;
	logic             closing;
	logic             accept;
	logic [17:0]      pair_mag;
	logic [SUM_W-1:0] sum_next;

	// Magnitude of a 16-bit two's complement sample; the most negative gives 32768.
	function automatic logic [16:0] magnitude(input logic signed [vag_pkg::SAMPLE_W-1:0] s);
		logic [16:0] m;
		if (s[vag_pkg::SAMPLE_W-1]) begin
			m = {1'b0, ~s} + 17'd1;
		end else begin
			m = {1'b0, s};
		end
		return m;
	endfunction

	// A closing frame needs room in the window register; others are always taken.
	assign closing     = (frame_cnt_q == LAST_FRAME);
	assign frame.ready = !closing || !win_valid_s1 || win_ready;
	assign accept      = frame.valid && frame.ready;

	// Running sum including the current frame.
	assign pair_mag = {1'b0, magnitude(frame.left_sample)} +
		{1'b0, magnitude(frame.right_sample)};
	assign sum_next = sum_q + SUM_W'(pair_mag);

	// Frame counter and running sum.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			frame_cnt_q <= '0;
			sum_q       <= '0;
		end else if (accept) begin
			if (closing) begin
				frame_cnt_q <= '0;
				sum_q       <= '0;
			end else begin
				frame_cnt_q <= frame_cnt_q + CNT_W'(1);
				sum_q       <= sum_next;
			end
		end
	end

	// Finished window register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			win_valid_s1 <= 1'b0;
		end else if (accept && closing) begin
			win_valid_s1 <= 1'b1;
		end else if (win_ready) begin
			win_valid_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (accept && closing) begin
			win_sum_s1 <= sum_next;
		end
	end

	assign win_valid = win_valid_s1;
	assign win_sum   = win_sum_s1;

endmodule

`default_nettype wire

// ===== hw/rtl/vag_avg_div.sv =====
// ----------------------------------------------------------------------------
// Voice activity gate window average
// Divides a window sum by twice the window length with an exact reciprocal.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module vag_avg_div #(
	parameter int WINDOW_FRAMES = vag_pkg::WINDOW_FRAMES_DEFAULT,
	parameter int SUM_W         = vag_pkg::sum_width(WINDOW_FRAMES)
) (
	input  wire logic                     clk,
	input  wire logic                     arst_n,
	input  wire logic                     in_valid,
	output logic                          in_ready,
	input  wire logic [SUM_W-1:0]         in_sum,
	output logic                          out_valid,
	input  wire logic                     out_ready,
	output logic [vag_pkg::AVG_W-1:0]     out_avg
);

	// With m = ceil(2^(N+l) / d) and 2^l >= d, floor(n * m / 2^(N+l)) equals
	// floor(n / d) for every n below 2^N.
	localparam int DIVISOR = 2 * WINDOW_FRAMES;
	localparam int DIV_L   = $clog2(DIVISOR);
	localparam int DIV_K   = SUM_W + DIV_L;
	localparam int M_W     = SUM_W + 1;
	localparam int PROD_W  = SUM_W + M_W;
	localparam logic [63:0] DIV_M_WIDE =
		((64'd1 << DIV_K) + 64'(DIVISOR) - 64'd1) / 64'(DIVISOR);
	localparam logic [M_W-1:0] DIV_M = DIV_M_WIDE[M_W-1:0];

	logic              prod_valid_s2;
	logic [PROD_W-1:0] prod_s2;

	assign in_ready = !prod_valid_s2 || out_ready;

	// Product stage valid.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			prod_valid_s2 <= 1'b0;
		end else if (in_ready) begin
			prod_valid_s2 <= in_valid;
		end
	end

	// Reciprocal multiply.
	always_ff @(posedge clk) begin
		if (in_valid && in_ready) begin
			prod_s2 <= PROD_W'(in_sum) * PROD_W'(DIV_M);
		end
	end

	assign out_valid = prod_valid_s2;
	assign out_avg   = prod_s2[DIV_K +: vag_pkg::AVG_W];

endmodule

`default_nettype wire

// ===== hw/rtl/vag_detect.sv =====
// ----------------------------------------------------------------------------
// Voice activity gate detector
// Steps the four-state detector once per window and holds the result.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module vag_detect (
	input  wire logic                     clk,
	input  wire logic                     arst_n,
	input  wire vag_pkg::vag_cfg_t        cfg,
	input  wire logic                     in_valid,
	output logic                          in_ready,
	input  wire logic [vag_pkg::AVG_W-1:0] in_avg,
	vag_result_if.source                  result
);

	vag_pkg::vag_state_t           state_q;
	vag_pkg::vag_state_t           state_d;
	logic [vag_pkg::REG_W-1:0]     quiet_q;
	logic [vag_pkg::REG_W-1:0]     quiet_d;
	logic [vag_pkg::AVG_W-1:0]     avg_q;
	logic                          valid_q;
	logic                          take;

	assign in_ready = !valid_q || result.ready;
	assign take     = in_valid && in_ready;

	// Next state and quiet count for the window being taken.
	always_comb begin
		vag_pkg::vag_state_t st;
		logic [vag_pkg::REG_W-1:0] qc;
		logic quiet_win;
		logic loud_win;

		quiet_win = (in_avg < cfg.noise_gate);
		loud_win  = (in_avg > cfg.start_threshold);
		qc        = quiet_q;

		// Transient states fall back before the window is judged.
		unique case (state_q)
			vag_pkg::VAG_SILENCE: st = vag_pkg::VAG_IDLE;
			vag_pkg::VAG_START:   st = vag_pkg::VAG_ONGOING;
			default:              st = state_q;
		endcase

		// Ongoing sound: count quiet windows up to the hangover limit.
		if (st == vag_pkg::VAG_ONGOING) begin
			if (quiet_win) begin
				if (qc < cfg.hangover_windows) begin
					qc = qc + 16'd1;
				end else begin
					st = vag_pkg::VAG_SILENCE;
					qc = '0;
				end
			end
			if ((qc != '0) && loud_win) begin
				qc = '0;
			end
		end

		// Idle: a loud window starts sound.
		if ((st == vag_pkg::VAG_IDLE) && loud_win) begin
			st = vag_pkg::VAG_START;
			qc = '0;
		end

		state_d = st;
		quiet_d = qc;
	end

	// Detector state, quiet count and result valid.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= vag_pkg::VAG_IDLE;
			quiet_q <= '0;
			valid_q <= 1'b0;
		end else begin
			if (take) begin
				state_q <= state_d;
				quiet_q <= quiet_d;
			end
			if (in_ready) begin
				valid_q <= in_valid;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (take) begin
			avg_q <= in_avg;
		end
	end

	assign result.valid          = valid_q;
	assign result.window_average = avg_q;
	assign result.detector_state = state_q;
	assign result.keep_window    = (state_q != vag_pkg::VAG_IDLE);

endmodule

`default_nettype wire

// ===== hw/rtl/voice_activity_gate_unit.sv =====
// A window's sum, product and result register in turn once its last frame is accepted.
// Throughput: one frame per cycle while not stalled; one result per WINDOW_FRAMES frames.
// The rate is set by the three-register chain: window sum, reciprocal product, result.
// A frame that does not close a window is accepted even while a result waits.
// Reset (arst_n low, asynchronous) clears the pipeline, the window sum and count,
// the detector to idle, and loads the register defaults 300, 800 and 20.
// ----------------------------------------------------------------------------
// Voice activity gate unit
// Energy threshold voice activity detector with hangover, top level.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none
`include "voice_activity_gate_unit_assert.svh"

module voice_activity_gate_unit #(
	parameter int WINDOW_FRAMES = vag_pkg::WINDOW_FRAMES_DEFAULT
) (
	input  wire logic                        clk,
	input  wire logic                        arst_n,
	vag_frame_if.sink                        frame,
	vag_result_if.source                     result,
	input  wire logic                        cfg_write,
	input  wire logic [vag_pkg::INDEX_W-1:0] cfg_index,
	input  wire logic [vag_pkg::REG_W-1:0]   cfg_data
);

	localparam int SUM_W = vag_pkg::sum_width(WINDOW_FRAMES);

	vag_pkg::vag_cfg_t           cfg_q;
	logic                        win_valid;
	logic                        win_ready;
	logic [SUM_W-1:0]            win_sum;
	logic                        avg_valid;
	logic                        avg_ready;
	logic [vag_pkg::AVG_W-1:0]   avg;

	// Configuration registers.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.noise_gate       <= vag_pkg::NOISE_GATE_RESET;
			cfg_q.start_threshold  <= vag_pkg::START_THRESHOLD_RESET;
			cfg_q.hangover_windows <= vag_pkg::HANGOVER_WINDOWS_RESET;
		end else if (cfg_write) begin
			unique case (cfg_index)
				vag_pkg::REG_NOISE_GATE:       cfg_q.noise_gate       <= cfg_data;
				vag_pkg::REG_START_THRESHOLD:  cfg_q.start_threshold  <= cfg_data;
				vag_pkg::REG_HANGOVER_WINDOWS: cfg_q.hangover_windows <= cfg_data;
				default: ;
			endcase
		end
	end

	// Window sum stage.
	vag_accum #(
		.WINDOW_FRAMES (WINDOW_FRAMES),
		.SUM_W         (SUM_W)
	) u_accum (
		.clk       (clk),
		.arst_n    (arst_n),
		.frame     (frame),
		.win_valid (win_valid),
		.win_ready (win_ready),
		.win_sum   (win_sum)
	);

	// Average stage.
	vag_avg_div #(
		.WINDOW_FRAMES (WINDOW_FRAMES),
		.SUM_W         (SUM_W)
	) u_avg_div (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (win_valid),
		.in_ready  (win_ready),
		.in_sum    (win_sum),
		.out_valid (avg_valid),
		.out_ready (avg_ready),
		.out_avg   (avg)
	);

	// Detector and result register.
	vag_detect u_detect (
		.clk      (clk),
		.arst_n   (arst_n),
		.cfg      (cfg_q),
		.in_valid (avg_valid),
		.in_ready (avg_ready),
		.in_avg   (avg),
		.result   (result)
	);

	// A window average can never exceed the largest sample magnitude.
	`VAG_ASSERT_IMPL(a_avg_bound, clk, arst_n, result.valid, result.window_average <= 16'd32768)

	// The keep flag follows the reported state.
	`VAG_ASSERT_IMPL(a_keep_state, clk, arst_n, result.valid,
		result.keep_window == (result.detector_state != vag_pkg::VAG_IDLE))

	// A new result only comes from a product that was waiting in the average stage.
	`VAG_ASSERT_IMPL(a_result_source, clk, arst_n, $rose(result.valid), $past(avg_valid))

	// A finished window sum that is not taken stays valid.
	`VAG_ASSERT_NEXT(a_win_hold, clk, arst_n, win_valid && !win_ready, win_valid)

endmodule

`default_nettype wire

// ===== tb/testbench.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Voice activity gate unit testbench
// Drives stereo PCM frames into the detector and checks every window result
// against a cycle-free predictor of the windowed average and detector state.
// A short table of directed frames and register writes comes first. Phases of
// shaped random frames follow, each with its own register setting. Random
// idle and stall bursts fall on both channels.
// ----------------------------------------------------------------------------

module testbench;

	localparam int WINDOW          = vag_pkg::WINDOW_FRAMES_DEFAULT;
	localparam int DRAIN_CYCLES    = 4;
	localparam int WATCHDOG_CYCLES = 2000;
	localparam int PHASES          = 7;

	localparam logic signed [vag_pkg::SAMPLE_W-1:0] PCM_MIN  = 16'sh8000;
	localparam logic signed [vag_pkg::SAMPLE_W-1:0] PCM_MAX  = 16'sh7fff;
	localparam logic signed [vag_pkg::SAMPLE_W-1:0] PCM_ZERO = 16'sh0000;

	// One finished window as reported on the result channel.
	typedef struct packed {
		logic [vag_pkg::AVG_W-1:0] avg;
		vag_pkg::vag_state_t       state;
		logic                      keep;
	} window_result_t;

	typedef enum {ROW_FRAMES, ROW_WRITE} row_kind_t;

	// One line of the directed table. A frame line sends the same frame count
	// times; a typed result applies to the frame that closes the window.
	typedef struct {
		row_kind_t                           kind;
		int                                  count;
		logic signed [vag_pkg::SAMPLE_W-1:0] left;
		logic signed [vag_pkg::SAMPLE_W-1:0] right;
		logic [vag_pkg::INDEX_W-1:0]         index;
		logic [vag_pkg::REG_W-1:0]           data;
		bit                                  typed;
		window_result_t                      want;
	} script_row_t;

	typedef enum {LVL_QUIET, LVL_MID, LVL_LOUD, LVL_ANY} level_t;

	logic                        clk;
	logic                        arst_n;
	logic                        cfg_write;
	logic [vag_pkg::INDEX_W-1:0] cfg_index;
	logic [vag_pkg::REG_W-1:0]   cfg_data;

	vag_frame_if  frame_ch ();
	vag_result_if result_ch ();

	voice_activity_gate_unit #(
		.WINDOW_FRAMES(WINDOW)
	) i_dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.frame     (frame_ch),
		.result    (result_ch),
		.cfg_write (cfg_write),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data)
	);

	// Predictor state: register copy, window accumulator and detector.
	vag_pkg::vag_cfg_t         regs;
	int unsigned               win_sum;
	int                        frames_seen;
	vag_pkg::vag_state_t       det_state;
	logic [vag_pkg::REG_W-1:0] quiet_cnt;

	window_result_t pending_windows [$];
	int             mismatch_count = 0;
	int             send_gap_odds;
	int             ready_stall_odds;
	int             idle_cycles = 0;

	// Window closing frames: most negative samples, a mid-window write that
	// drops the hangover to zero, and a sum that rounds down in the division.
	script_row_t directed_script [5] = '{
		'{ROW_FRAMES, 8, PCM_MIN, PCM_MIN, vag_pkg::REG_NOISE_GATE, 16'd0, 1'b1,
			'{16'd32768, vag_pkg::VAG_START, 1'b1}},
		'{ROW_FRAMES, 4, PCM_ZERO, PCM_ZERO, vag_pkg::REG_NOISE_GATE, 16'd0, 1'b0, '0},
		'{ROW_WRITE, 1, PCM_ZERO, PCM_ZERO, vag_pkg::REG_HANGOVER_WINDOWS, 16'd0, 1'b0,
			'0},
		'{ROW_FRAMES, 4, PCM_ZERO, PCM_ZERO, vag_pkg::REG_NOISE_GATE, 16'd0, 1'b1,
			'{16'd0, vag_pkg::VAG_SILENCE, 1'b1}},
		'{ROW_FRAMES, 8, PCM_MAX, PCM_MIN, vag_pkg::REG_NOISE_GATE, 16'd0, 1'b1,
			'{16'd32767, vag_pkg::VAG_START, 1'b1}}
	};

	int gap_odds_by_phase   [PHASES] = '{4, 0, 2, 8, 3, 5, 0};
	int stall_odds_by_phase [PHASES] = '{3, 6, 0, 2, 8, 4, 0};

	// Clock.
	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	function automatic int unsigned sample_magnitude(
			input logic signed [vag_pkg::SAMPLE_W-1:0] s);
		int v;
		v = s;
		return (v < 0) ? -v : v;
	endfunction

	// Adds one frame to the window; at a window end steps the detector and
	// returns 1 with the expected result.
	function automatic bit accumulate_frame(input logic signed [vag_pkg::SAMPLE_W-1:0] left,
			input logic signed [vag_pkg::SAMPLE_W-1:0] right, output window_result_t res);
		int unsigned avg;
		res = '0;
		win_sum += sample_magnitude(left) + sample_magnitude(right);
		frames_seen++;
		if (frames_seen < WINDOW) begin
			return 1'b0;
		end
		avg = win_sum / (2 * WINDOW);
		win_sum = 0;
		frames_seen = 0;

		// Transient states last one window.
		if (det_state == vag_pkg::VAG_SILENCE) begin
			det_state = vag_pkg::VAG_IDLE;
		end
		if (det_state == vag_pkg::VAG_START) begin
			det_state = vag_pkg::VAG_ONGOING;
		end

		// Hangover count while sound is ongoing.
		if (det_state == vag_pkg::VAG_ONGOING) begin
			if (avg < regs.noise_gate) begin
				if (quiet_cnt < regs.hangover_windows) begin
					quiet_cnt = quiet_cnt + 16'd1;
				end else begin
					det_state = vag_pkg::VAG_SILENCE;
					quiet_cnt = '0;
				end
			end
			if (quiet_cnt != 0 && avg > regs.start_threshold) begin
				quiet_cnt = '0;
			end
		end

		if (det_state == vag_pkg::VAG_IDLE && avg > regs.start_threshold) begin
			det_state = vag_pkg::VAG_START;
			quiet_cnt = '0;
		end

		res.avg   = avg[vag_pkg::AVG_W-1:0];
		res.state = det_state;
		res.keep  = (det_state != vag_pkg::VAG_IDLE);
		return 1'b1;
	endfunction

	task automatic flag_mismatch(input string what);
		$display("[%0t] mismatch: %s", $realtime, what);
		mismatch_count++;
	endtask

	// Result channel ready: random stall bursts.
	initial begin
		int stall_left;
		stall_left = 0;
		result_ch.ready = 1'b0;
		forever begin
			@(negedge clk);
			if (stall_left > 0) begin
				stall_left--;
				result_ch.ready <= 1'b0;
			end else if (ready_stall_odds != 0 && $urandom_range(ready_stall_odds - 1) == 0) begin
				stall_left = $urandom_range(17, 1) - 1;
				result_ch.ready <= 1'b0;
			end else begin
				result_ch.ready <= 1'b1;
			end
		end
	end

	// Result checker: each result transaction against the oldest expectation.
	always @(posedge clk) begin : check_results
		window_result_t want;
		if (arst_n && result_ch.valid && result_ch.ready) begin
			if (pending_windows.size() == 0) begin
				flag_mismatch($sformatf("unexpected result avg %0d state %0d keep %0b",
					result_ch.window_average, result_ch.detector_state,
					result_ch.keep_window));
			end else begin
				want = pending_windows.pop_front();
				if (result_ch.window_average !== want.avg) begin
					flag_mismatch($sformatf("window_average %0d, expected %0d",
						result_ch.window_average, want.avg));
				end
				if (result_ch.detector_state !== want.state) begin
					flag_mismatch($sformatf("detector_state %0d, expected %0d",
						result_ch.detector_state, want.state));
				end
				if (result_ch.keep_window !== want.keep) begin
					flag_mismatch($sformatf("keep_window %0b, expected %0b",
						result_ch.keep_window, want.keep));
				end
			end
		end
	end

	// Watchdog: ends the run after a long stretch with no transaction.
	always @(posedge clk) begin
		if (arst_n) begin
			if ((frame_ch.valid && frame_ch.ready) || (result_ch.valid && result_ch.ready)) begin
				idle_cycles <= 0;
			end else if (idle_cycles >= WATCHDOG_CYCLES) begin
				$display("testbench: errors");
				$finish;
			end else begin
				idle_cycles <= idle_cycles + 1;
			end
		end
	end

	// Sends one frame, with an optional idle burst first. Called and left at
	// a falling edge. A typed result replaces the predicted one.
	task automatic send_frame(input logic signed [vag_pkg::SAMPLE_W-1:0] left,
			input logic signed [vag_pkg::SAMPLE_W-1:0] right, input bit typed,
			input window_result_t typed_result);
		window_result_t predicted;
		int gap;
		gap = 0;
		if (send_gap_odds != 0 && $urandom_range(send_gap_odds - 1) == 0) begin
			gap = $urandom_range(17, 1);
		end
		if (gap > 0) begin
			frame_ch.valid <= 1'b0;
			repeat (gap) @(negedge clk);
		end
		frame_ch.valid        <= 1'b1;
		frame_ch.left_sample  <= left;
		frame_ch.right_sample <= right;
		do @(posedge clk); while (!frame_ch.ready);
		if (accumulate_frame(left, right, predicted)) begin
			pending_windows.push_back(typed ? typed_result : predicted);
		end
		@(negedge clk);
	endtask

	// Waits until every expected result has arrived and the pipeline is empty.
	task automatic drain_pipeline();
		frame_ch.valid <= 1'b0;
		while (pending_windows.size() != 0) @(negedge clk);
		repeat (DRAIN_CYCLES) @(negedge clk);
	endtask

	// One register write; the write enable stays high for the caller to drop.
	task automatic write_reg(input logic [vag_pkg::INDEX_W-1:0] index,
			input logic [vag_pkg::REG_W-1:0] value);
		cfg_write <= 1'b1;
		cfg_index <= index;
		cfg_data  <= value;
		case (index)
			vag_pkg::REG_NOISE_GATE:       regs.noise_gate       = value;
			vag_pkg::REG_START_THRESHOLD:  regs.start_threshold  = value;
			vag_pkg::REG_HANGOVER_WINDOWS: regs.hangover_windows = value;
			default: ;
		endcase
		@(negedge clk);
	endtask

	function automatic logic signed [vag_pkg::SAMPLE_W-1:0] shaped_sample(
			input int unsigned lo, input int unsigned hi);
		int unsigned m;
		m = $urandom_range(hi, lo);
		if (m >= 32768) begin
			return PCM_MIN;
		end
		return $urandom_range(1) ? 16'(-int'(m)) : 16'(m);
	endfunction

	// One phase of random frames under one register setting. The loudness
	// level holds over stretches of windows so the hangover runs out.
	task automatic run_phase(input logic [vag_pkg::REG_W-1:0] gate,
			input logic [vag_pkg::REG_W-1:0] thresh,
			input logic [vag_pkg::REG_W-1:0] hang, input int frames);
		level_t level;
		int unsigned gate_c;
		int unsigned thresh_c;
		int unsigned lo;
		int unsigned hi;
		logic signed [vag_pkg::SAMPLE_W-1:0] left;
		logic signed [vag_pkg::SAMPLE_W-1:0] right;
		drain_pipeline();
		write_reg(vag_pkg::REG_NOISE_GATE, gate);
		write_reg(vag_pkg::REG_START_THRESHOLD, thresh);
		write_reg(vag_pkg::REG_HANGOVER_WINDOWS, hang);
		cfg_write <= 1'b0;
		gate_c   = (gate > 32768) ? 32768 : 32'(gate);
		thresh_c = (thresh > 32768) ? 32768 : 32'(thresh);
		level    = LVL_LOUD;
		for (int n = 0; n < frames; n++) begin
			if (n % WINDOW == 0 && $urandom_range(3) == 0) begin
				level = level_t'($urandom_range(3));
			end
			case (level)
				LVL_QUIET: begin
					lo = 0;
					hi = (gate_c == 0) ? 0 : gate_c - 1;
				end
				LVL_MID: begin
					lo = gate_c;
					hi = thresh_c;
				end
				LVL_LOUD: begin
					lo = thresh_c;
					hi = 32768;
				end
				default: begin
					lo = 0;
					hi = 0;
				end
			endcase
			if (level == LVL_ANY) begin
				left  = 16'($urandom);
				right = 16'($urandom);
			end else begin
				left  = shaped_sample(lo, hi);
				right = shaped_sample(lo, hi);
			end
			send_frame(left, right, 1'b0, '0);
		end
	endtask

	// Stimulus: reset, directed table, random phases, final drain.
	initial begin
		win_sum               = 0;
		frames_seen           = 0;
		det_state             = vag_pkg::VAG_IDLE;
		quiet_cnt             = '0;
		regs.noise_gate       = vag_pkg::NOISE_GATE_RESET;
		regs.start_threshold  = vag_pkg::START_THRESHOLD_RESET;
		regs.hangover_windows = vag_pkg::HANGOVER_WINDOWS_RESET;
		send_gap_odds         = 0;
		ready_stall_odds      = 0;
		arst_n                = 1'b0;
		cfg_write             = 1'b0;
		cfg_index             = '0;
		cfg_data              = '0;
		frame_ch.valid        = 1'b0;
		frame_ch.left_sample  = '0;
		frame_ch.right_sample = '0;

		repeat (9) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;
		@(negedge clk);

		// Directed table under the reset register values.
		send_gap_odds    = 4;
		ready_stall_odds = 4;
		foreach (directed_script[i]) begin
			if (directed_script[i].kind == ROW_WRITE) begin
				drain_pipeline();
				write_reg(directed_script[i].index, directed_script[i].data);
				cfg_write <= 1'b0;
			end else begin
				for (int k = 0; k < directed_script[i].count; k++) begin
					send_frame(directed_script[i].left, directed_script[i].right,
						directed_script[i].typed && k == directed_script[i].count - 1,
						directed_script[i].want);
				end
			end
		end

		// Random phases: register extremes first, then typical settings, and the reset
		// gate and threshold with hangover 3 and no idling at the end.
		for (int p = 0; p < PHASES; p++) begin
			logic [vag_pkg::REG_W-1:0] gate;
			logic [vag_pkg::REG_W-1:0] thresh;
			logic [vag_pkg::REG_W-1:0] hang;
			case (p)
				0: begin
					gate = 16'd0; thresh = 16'd0; hang = 16'd0;
				end
				1: begin
					gate = 16'hffff; thresh = 16'd0; hang = 16'hffff;
				end
				2: begin
					gate = 16'd32768; thresh = 16'd32768; hang = 16'd1;
				end
				PHASES - 1: begin
					gate = vag_pkg::NOISE_GATE_RESET;
					thresh = vag_pkg::START_THRESHOLD_RESET;
					hang = 16'd3;
				end
				default: begin
					gate   = 16'($urandom_range(3000, 100));
					thresh = gate + 16'($urandom_range(3000, 0));
					hang   = 16'($urandom_range(6, 0));
				end
			endcase
			send_gap_odds    = gap_odds_by_phase[p];
			ready_stall_odds = stall_odds_by_phase[p];
			run_phase(gate, thresh, hang, $urandom_range(135, 110));
		end

		// Wait out every expected result, then the pipeline latency.
		frame_ch.valid <= 1'b0;
		while (pending_windows.size() != 0) @(posedge clk);
		repeat (2 * DRAIN_CYCLES) @(posedge clk);
		if (mismatch_count == 0) begin
			$display("testbench: clean");
		end else begin
			$display("testbench: errors");
		end
		$finish;
	end

endmodule
